// File: hdl/rose_pkg.sv
// rose_pkg: shared types, codes and constants for the range order statistics unit
// no dependencies; compiled first
`default_nettype none

package rose_pkg;

  // fixed field widths
  localparam int DATA_W    = 32;
  localparam int POS_W     = 10;
  localparam int OP_W      = 3;
  localparam int DEPTH_DEF = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_RANK  = 3'd1;
  localparam logic [OP_W-1:0] OP_KTH   = 3'd2;
  localparam logic [OP_W-1:0] OP_PRED  = 3'd3;
  localparam logic [OP_W-1:0] OP_SUCC  = 3'd4;

  // input transaction payload
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         left_pos;
    logic [POS_W-1:0]         right_pos;
    logic signed [DATA_W-1:0] operand_value;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic signed [DATA_W-1:0] answer;
    logic                     found;
  } out_item_t;

  // query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_SCAN,
    ST_TAIL,
    ST_EVAL,
    ST_DONE
  } rose_state_t;

endpackage

`default_nettype wire

// File: hdl/rose_if.sv
// rose_if: valid/ready channel interfaces for input and result transactions
// depends on rose_pkg
`default_nettype none

interface rose_in_if import rose_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rose_out_if import rose_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/rose_mem.sv
// rose_mem: single-port-write, single-port-read value store with registered read data
// depends on rose_pkg
`default_nettype none

module rose_mem import rose_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic signed [DATA_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0]      rd_data
);

  logic signed [DATA_W-1:0] mem_r [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/rose_engine.sv
// rose_engine: query sequencer; scans the store once per pass and folds each entry
// depends on rose_pkg, rose_if; drives the ports of rose_mem
`default_nettype none

module rose_engine import rose_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  rose_in_if.sink                       in_chan,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output out_item_t                     res_item,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic signed [DATA_W-1:0]      mem_wr_data,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr,
  input  wire logic signed [DATA_W-1:0] mem_rd_data
);

  // position width covers both the field and the store address
  localparam int XW   = (POS_W > AW) ? POS_W : AW;
  localparam int LIMW = XW + 1;
  localparam logic [LIMW-1:0] DEPTH_L = LIMW'(DEPTH);
  localparam logic [XW-1:0]   LAST_X  = XW'(DEPTH - 1);

  rose_state_t state_r, state_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic [XW-1:0]            lo_r, lo_nxt;
  logic [XW-1:0]            hi_r, hi_nxt;
  logic [XW-1:0]            addr_r, addr_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt;
  logic signed [DATA_W-1:0] b_r, b_nxt;
  logic signed [DATA_W-1:0] m_r, m_nxt;
  logic signed [DATA_W-1:0] best_r, best_nxt;
  logic                     bfound_r, bfound_nxt;
  logic [LIMW-1:0]          cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  out_item_t                res_r, res_nxt;

  logic                     accept;
  logic [XW-1:0]            in_lo, in_hi_raw, in_hi;
  logic                     in_empty;
  logic [LIMW-1:0]          in_total;
  logic                     k_ok;
  logic signed [DATA_W-1:0] v;
  logic                     hit;
  logic [DATA_W:0]          span;
  logic [DATA_W:0]          mid_sum;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // decode incoming range: clip the end, detect an empty range, check k
  always_comb begin
    in_lo     = XW'(in_chan.payload.left_pos);
    in_hi_raw = XW'(in_chan.payload.right_pos);
    in_hi     = ({1'b0, in_hi_raw} >= DEPTH_L) ? LAST_X : in_hi_raw;
    in_empty  = ({1'b0, in_lo} >= DEPTH_L) || (in_lo > in_hi);
    in_total  = {1'b0, in_hi} - {1'b0, in_lo} + LIMW'(1);
    k_ok      = (in_chan.payload.operand_value > 32'sd0) &&
                ($unsigned(in_chan.payload.operand_value) <= 32'(in_total));
  end

  // write path straight from the input transaction
  assign mem_wr_en   = accept && (in_chan.payload.operation == OP_WRITE) &&
                       ({1'b0, in_lo} < DEPTH_L);
  assign mem_wr_addr = in_lo[AW-1:0];
  assign mem_wr_data = in_chan.payload.operand_value;

  // scan read port
  assign mem_rd_en   = (state_r == ST_SCAN);
  assign mem_rd_addr = addr_r[AW-1:0];

  // per-entry compare and bisection midpoint
  always_comb begin
    v       = mem_rd_data;
    hit     = (op_r == OP_KTH) ? (v <= m_r) : (v < x_r);
    span    = {b_r[DATA_W-1], b_r} - {a_r[DATA_W-1], a_r};
    mid_sum = {a_r[DATA_W-1], a_r} + (span >> 1);
  end

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    addr_nxt   = addr_r;
    x_nxt      = x_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    m_nxt      = m_r;
    best_nxt   = best_r;
    bfound_nxt = bfound_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = (state_r == ST_SCAN);
    res_nxt    = res_r;
    res_valid  = 1'b0;

    // fold the entry read in the previous cycle
    if (pend_r) begin
      if (hit) begin
        cnt_nxt = cnt_r + LIMW'(1);
      end
      if (op_r == OP_PRED) begin
        if ((v < x_r) && (!bfound_r || (v > best_r))) begin
          best_nxt   = v;
          bfound_nxt = 1'b1;
        end
      end else if (op_r == OP_SUCC) begin
        if ((v > x_r) && (!bfound_r || (v < best_r))) begin
          best_nxt   = v;
          bfound_nxt = 1'b1;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_chan.payload.operation;
          lo_nxt     = in_lo;
          hi_nxt     = in_hi;
          addr_nxt   = in_lo;
          x_nxt      = in_chan.payload.operand_value;
          cnt_nxt    = '0;
          bfound_nxt = 1'b0;
          a_nxt      = {1'b1, {(DATA_W-1){1'b0}}};
          b_nxt      = {1'b0, {(DATA_W-1){1'b1}}};
          case (in_chan.payload.operation) inside
            OP_RANK, OP_KTH, OP_PRED, OP_SUCC: begin
              if (in_empty || ((in_chan.payload.operation == OP_KTH) && !k_ok)) begin
                res_nxt.found  = (in_chan.payload.operation == OP_RANK);
                res_nxt.answer = (in_chan.payload.operation == OP_RANK) ? 32'sd1 : 32'sd0;
                state_nxt      = ST_DONE;
              end else if (in_chan.payload.operation == OP_KTH) begin
                state_nxt = ST_MID;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              // write or unused code: nothing further
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // bisection step: finished interval or start a counting pass
      ST_MID: begin
        if (a_r == b_r) begin
          res_nxt.answer = a_r;
          res_nxt.found  = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          m_nxt     = mid_sum[DATA_W-1:0];
          cnt_nxt   = '0;
          addr_nxt  = lo_r;
          state_nxt = ST_SCAN;
        end
      end

      // issue one read per cycle over lo..hi
      ST_SCAN: begin
        addr_nxt = XW'(addr_r + XW'(1));
        if (addr_r == hi_r) begin
          state_nxt = ST_TAIL;
        end
      end

      // last read data is folded here
      ST_TAIL: begin
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        case (op_r)
          OP_KTH: begin
            if (32'(cnt_r) >= $unsigned(x_r)) begin
              b_nxt = m_r;
            end else begin
              a_nxt = m_r + 32'sd1;
            end
            state_nxt = ST_MID;
          end
          OP_RANK: begin
            res_nxt.answer = $signed(32'(cnt_r) + 32'd1);
            res_nxt.found  = 1'b1;
            state_nxt      = ST_DONE;
          end
          default: begin
            res_nxt.answer = bfound_r ? best_r : 32'sd0;
            res_nxt.found  = bfound_r;
            state_nxt      = ST_DONE;
          end
        endcase
      end

      // hand the result to the output register
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    addr_r   <= addr_nxt;
    x_r      <= x_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    m_r      <= m_nxt;
    best_r   <= best_nxt;
    bfound_r <= bfound_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  assign res_item = res_r;

endmodule

`default_nettype wire

// File: hdl/range_order_statistics_unit.sv
// Range order statistics unit: a store of DEPTH signed 32-bit values with
// write, rank, k-th smallest, predecessor and successor over a position range.
//
// Channels: in_chan carries one operation per transaction (operation, left_pos,
// right_pos, operand_value); out_chan carries answer and found. A write gives no
// result transaction; every query gives exactly one.
// Rank, predecessor and successor read the range once from the value store,
// one entry per cycle. K-th smallest bisects the 32-bit value space, one
// full counting pass of the range per step, 32 passes. The store has a
// single read port. Empty ranges and an out-of-range k skip the scan and
// go straight to the result.
// Throughput: one operation at a time; in_chan.ready is high only while the
// sequencer is idle.
// Reset (synchronous, rst_n low) clears the sequencer and the output valid flag;
// store contents are undefined until written.
// Stall: a result waits in the output register while out_chan.ready is low, and
// the next query may run meanwhile; its own result is held until the register frees.
// Depends on rose_pkg, rose_if, rose_mem, rose_engine.
`default_nettype none

module range_order_statistics_unit import rose_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rose_in_if.sink   in_chan,
  rose_out_if.source out_chan
);

  localparam int AW = $clog2(DEPTH);

  logic                     res_valid;
  logic                     res_ready;
  out_item_t                res_item;
  logic                     mem_wr_en;
  logic [AW-1:0]            mem_wr_addr;
  logic signed [DATA_W-1:0] mem_wr_data;
  logic                     mem_rd_en;
  logic [AW-1:0]            mem_rd_addr;
  logic signed [DATA_W-1:0] mem_rd_data;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  rose_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rose_engine #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

endmodule

`default_nettype wire
